>>> hdl/edge_detect_3x3_defines.svh
// Assertion macros for the edge detector.
// Used by the top level only; expects a clock named aclk in scope.
`ifndef EDGE_DETECT_3X3_DEFINES_SVH
`define EDGE_DETECT_3X3_DEFINES_SVH

// Check that a condition implies another in the same cycle
`define ED_ASSERT_NOW(lbl, a, b, msg) \
    lbl: assert property (@(posedge aclk) (a) |-> (b)) else $error(msg);

// Check that a condition implies another in the next cycle
`define ED_ASSERT_NEXT(lbl, a, b, msg) \
    lbl: assert property (@(posedge aclk) (a) |=> (b)) else $error(msg);

`endif

>>> hdl/ed_pkg.sv
// Shared types and constants for the 3x3 edge detector.
// No dependencies.
`default_nettype none
package ed_pkg;
    localparam int DEF_MAX_WIDTH = 1024;
    localparam int ADDR_W        = 13;
    localparam int PIX_W         = 24;
    localparam int HEIGHT_MAX    = 4096;
    localparam int CFG_W         = 13;

    typedef enum logic [0:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } reg_index_t;

    typedef enum logic [0:0] {
        OP_PIXEL = 1'b0,
        OP_DRAIN = 1'b1
    } op_t;

    // One classified beat handed from front to back
    typedef struct packed {
        op_t                 op;
        logic [ADDR_W-1:0]   addr;
        logic [PIX_W-1:0]    pix;
        logic                emit;
        logic                interior;
        logic                frame_end;
    } job_t;

    // Laplacian of one 8-bit channel, clamped to 0..255
    function automatic logic [7:0] lap_clamp(input logic [PIX_W*9-1:0] win, input int sh);
        logic signed [12:0] acc;
        acc = 13'(win[4*PIX_W+sh +: 8]) <<< 3;
        for (int k = 0; k < 9; k++) begin
            if (k != 4) acc = acc - 13'(win[k*PIX_W+sh +: 8]);
        end
        if (acc < 0) return 8'd0;
        if (acc > 13'sd255) return 8'd255;
        return acc[7:0];
    endfunction
endpackage
`default_nettype wire

>>> hdl/edge_detect_3x3.sv
// Top level of the streaming 3x3 Laplacian edge detector.
// Depends on ed_pkg, ed_front, ed_queue, ed_back and edge_detect_3x3_defines.svh.
//
//  Group   Dir  Fields (lowest bit first)
//  s_      in   tuser: operation; tdata: red_in, green_in, blue_in
//  m_      out  tlast: frame_end; tdata: red_out, green_out, blue_out
//  cfg_    in   index 0 frame_width, 1 frame_height
//
// One beat per clock sustained while m_tready stays high; a result passes the job queue,
// the registered line buffer read, the window stage and the output register.
// Reset is synchronous; the line buffers are not cleared.
// A stall on m_ backs up the four-entry job queue before s_tready drops.
`default_nettype none
`include "edge_detect_3x3_defines.svh"
module edge_detect_3x3 #(
    parameter int MAX_WIDTH = ed_pkg::DEF_MAX_WIDTH
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      cfg_wr_en,
    input  wire logic                      cfg_wr_index,
    input  wire logic [ed_pkg::CFG_W-1:0]  cfg_wr_data,
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    input  wire logic [23:0]               s_tdata,  // red_in, green_in, blue_in
    input  wire logic                      s_tuser,  // operation
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    output logic [23:0]                    m_tdata,  // red_out, green_out, blue_out
    output logic                           m_tlast
);
    import ed_pkg::*;

    logic q_full, push, pop, q_valid;
    job_t push_job, q_job;

    assign s_tready = !q_full;

    ed_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_index(cfg_wr_index), .cfg_wr_data(cfg_wr_data),
        .in_beat(s_tvalid && s_tready), .in_op(s_tuser), .in_pix(s_tdata),
        .push(push), .push_job(push_job)
    );

    ed_queue u_queue (
        .aclk(aclk), .aresetn(aresetn), .push(push), .push_job(push_job),
        .full(q_full), .pop(pop), .q_valid(q_valid), .q_job(q_job)
    );

    ed_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
        .aclk(aclk), .aresetn(aresetn), .q_valid(q_valid), .q_job(q_job), .pop(pop),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    `ED_ASSERT_NEXT(a_reset_quiet, !aresetn, !m_tvalid, "result valid after reset")
    `ED_ASSERT_NOW(a_end_zero, aresetn && m_tvalid && m_tlast, m_tdata == 24'd0,
        "frame end result not in border")
endmodule
`default_nettype wire

>>> hdl/ed_queue.sv
// Short job queue between front and back of the edge detector.
// Depends on ed_pkg.
`default_nettype none
module ed_queue (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        push,
    input  ed_pkg::job_t     push_job,
    output logic             full,
    input  wire logic        pop,
    output logic             q_valid,
    output ed_pkg::job_t     q_job
);
    import ed_pkg::*;
    localparam int DEPTH = 4;

    job_t       mem_reg [DEPTH];
    logic [1:0] wr_reg, rd_reg;
    logic [2:0] cnt_reg, cnt_next;

    assign full    = (cnt_reg == 3'(DEPTH));
    assign q_valid = (cnt_reg != 3'd0);
    assign q_job   = mem_reg[rd_reg];

    always_comb begin
        cnt_next = cnt_reg + 3'(push) - 3'(pop && q_valid);
    end

    // Advance pointers and count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) wr_reg <= wr_reg + 2'd1;
            if (pop && q_valid) rd_reg <= rd_reg + 2'd1;
            cnt_reg <= cnt_next;
        end
    end

    // Store entries
    always_ff @(posedge aclk) begin
        if (push) mem_reg[wr_reg] <= push_job;
    end
endmodule
`default_nettype wire

>>> hdl/ed_front.sv
// Front end: accepts beats, tracks frame position and drain, classifies jobs.
// Depends on ed_pkg.
`default_nettype none
module ed_front #(
    parameter int MAX_WIDTH = ed_pkg::DEF_MAX_WIDTH
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      cfg_wr_en,
    input  wire logic                      cfg_wr_index,
    input  wire logic [ed_pkg::CFG_W-1:0]  cfg_wr_data,
    input  wire logic                      in_beat,
    input  wire logic                      in_op,
    input  wire logic [ed_pkg::PIX_W-1:0]  in_pix,
    output logic                           push,
    output ed_pkg::job_t                   push_job
);
    import ed_pkg::*;
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int EW = ((CW + 1 > 11) ? CW + 1 : 11) + 1;

    logic [10:0]   fw_reg;
    logic [12:0]   fh_reg;
    logic [CW-1:0] col_reg;
    logic [11:0]   row_reg;
    logic [EW-1:0] drain_reg;
    logic          full_reg;

    logic [EW-1:0] eff_w, col_inc, drain_inc, total;
    logic [12:0]   eff_h, row_inc;
    logic          row_done, drain_done;

    // Clamp registers to their usable range
    always_comb begin
        if (fw_reg == 11'd0) eff_w = EW'(1);
        else if (EW'(fw_reg) > EW'(MAX_WIDTH)) eff_w = EW'(MAX_WIDTH);
        else eff_w = EW'(fw_reg);
        if (fh_reg == 13'd0) eff_h = 13'd1;
        else if (fh_reg > 13'(HEIGHT_MAX)) eff_h = 13'(HEIGHT_MAX);
        else eff_h = fh_reg;
        col_inc    = EW'(col_reg) + EW'(1);
        row_inc    = 13'(row_reg) + 13'd1;
        drain_inc  = drain_reg + EW'(1);
        total      = (eff_h == 13'd1) ? eff_w : eff_w + EW'(1);
        row_done   = (col_inc >= eff_w);
        drain_done = (drain_inc >= total);
    end

    // Classify the incoming beat
    always_comb begin
        push_job.op        = op_t'(in_op);
        push_job.addr      = ADDR_W'(col_reg);
        push_job.pix       = in_pix;
        push_job.emit      = (row_reg >= 12'd2) || (row_reg == 12'd1 && col_reg != '0);
        push_job.interior  = (row_reg >= 12'd2) && (EW'(col_reg) >= EW'(2));
        push_job.frame_end = drain_done;
        if (in_op == OP_DRAIN) begin
            push_job.emit     = 1'b1;
            push_job.interior = 1'b0;
        end else begin
            push_job.frame_end = 1'b0;
        end
        push = in_beat && ((in_op == OP_DRAIN) ? full_reg : !full_reg);
    end

    // Update registers and frame position
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fw_reg    <= 11'd1024;
            fh_reg    <= 13'd1024;
            col_reg   <= '0;
            row_reg   <= '0;
            drain_reg <= '0;
            full_reg  <= 1'b0;
        end else if (cfg_wr_en) begin
            if (cfg_wr_index == REG_FRAME_WIDTH) fw_reg <= cfg_wr_data[10:0];
            else fh_reg <= cfg_wr_data;
            col_reg   <= '0;
            row_reg   <= '0;
            drain_reg <= '0;
            full_reg  <= 1'b0;
        end else if (push) begin
            if (in_op == OP_DRAIN) begin
                if (drain_done) begin
                    col_reg   <= '0;
                    row_reg   <= '0;
                    drain_reg <= '0;
                    full_reg  <= 1'b0;
                end else begin
                    drain_reg <= drain_inc;
                end
            end else if (row_done) begin
                col_reg <= '0;
                row_reg <= row_inc[11:0];
                if (row_inc >= eff_h) full_reg <= 1'b1;
            end else begin
                col_reg <= col_inc[CW-1:0];
            end
        end
    end
endmodule
`default_nettype wire

>>> hdl/ed_back.sv
// Back end: line buffer memory, 3x3 window, Laplacian and output register.
// Depends on ed_pkg.
`default_nettype none
module ed_back #(
    parameter int MAX_WIDTH = ed_pkg::DEF_MAX_WIDTH
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      q_valid,
    input  ed_pkg::job_t                   q_job,
    output logic                           pop,
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    output logic [ed_pkg::PIX_W-1:0]       m_tdata,
    output logic                           m_tlast
);
    import ed_pkg::*;
    localparam int CW = $clog2(MAX_WIDTH);

    // Each entry holds {upper line, lower line}
    logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
    logic [2*PIX_W-1:0] rd_reg;
    logic [PIX_W*9-1:0] win_reg;
    logic               s1_valid_reg, s2_valid_reg, out_valid_reg;
    job_t               s1_job_reg, s2_job_reg;
    logic [PIX_W-1:0]   out_data_reg;
    logic               out_last_reg;
    logic               adv;
    logic [PIX_W-1:0]   edge_pix;

    assign adv      = !out_valid_reg || m_tready;
    assign pop      = adv;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    always_comb begin
        edge_pix = {lap_clamp(win_reg, 16), lap_clamp(win_reg, 8), lap_clamp(win_reg, 0)};
    end

    // Read line buffers, write back shifted column
    always_ff @(posedge aclk) begin
        if (adv) begin
            if (q_valid && q_job.op == OP_PIXEL) rd_reg <= line_mem[q_job.addr[CW-1:0]];
            if (s1_valid_reg && s1_job_reg.op == OP_PIXEL)
                line_mem[s1_job_reg.addr[CW-1:0]] <= {rd_reg[PIX_W-1:0], s1_job_reg.pix};
        end
    end

    // Shift the window, hold payload registers on stall
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg <= '0;
        end else if (adv && s1_valid_reg && s1_job_reg.op == OP_PIXEL) begin
            win_reg[0*PIX_W +: 2*PIX_W] <= win_reg[1*PIX_W +: 2*PIX_W];
            win_reg[2*PIX_W +: PIX_W]   <= rd_reg[2*PIX_W-1:PIX_W];
            win_reg[3*PIX_W +: 2*PIX_W] <= win_reg[4*PIX_W +: 2*PIX_W];
            win_reg[5*PIX_W +: PIX_W]   <= rd_reg[PIX_W-1:0];
            win_reg[6*PIX_W +: 2*PIX_W] <= win_reg[7*PIX_W +: 2*PIX_W];
            win_reg[8*PIX_W +: PIX_W]   <= s1_job_reg.pix;
        end
    end

    // Advance the pipeline stages
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            s1_valid_reg  <= q_valid;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg && s2_job_reg.emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_job_reg   <= q_job;
            s2_job_reg   <= s1_job_reg;
            out_data_reg <= s2_job_reg.interior ? edge_pix : '0;
            out_last_reg <= s2_job_reg.frame_end;
        end
    end
endmodule
`default_nettype wire

>>> tb/tb_edge_detect_3x3.sv
// Self-checking bench for the streaming 3x3 Laplacian edge detector.
// Predicts each result beat from its own line buffers and window and
// compares it against m_ beats. Depends on ed_pkg and edge_detect_3x3.
`timescale 1ns / 100ps
`default_nettype none
module tb_edge_detect_3x3;
    import ed_pkg::*;

    localparam int MAXW = 1024;

    typedef struct packed {
        op_t        op;
        logic [7:0] blu;
        logic [7:0] grn;
        logic [7:0] red;
    } pix_beat_t;

    typedef struct packed {
        logic       last;
        logic [7:0] blu;
        logic [7:0] grn;
        logic [7:0] red;
    } edge_beat_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic cfg_wr_index = 1'b0;
    logic [CFG_W-1:0] cfg_wr_data = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [23:0] s_tdata = '0;
    logic s_tuser = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic m_tlast;

    edge_detect_3x3 dut (.*);

    always #5 aclk = ~aclk;

    // Predictor state
    logic [23:0] up_line [MAXW];
    logic [23:0] lo_line [MAXW];
    logic [23:0] win [9];
    int col_at, row_at, drained;
    bit full_frame;
    logic [10:0] width_reg;
    logic [12:0] height_reg;

    pix_beat_t  pend_q[$];
    edge_beat_t edge_q[$];
    int errors = 0;
    int send_idle = 21, recv_idle = 57;
    bit hold_send = 1'b0;

    function automatic int eff_w();
        if (width_reg == 0) return 1;
        if (width_reg > MAXW) return MAXW;
        return int'(width_reg);
    endfunction

    function automatic int eff_h();
        if (height_reg == 0) return 1;
        if (height_reg > 4096) return 4096;
        return int'(height_reg);
    endfunction

    function automatic logic [7:0] clamp_lap(int sh);
        int acc;
        acc = 8 * int'(win[4][sh +: 8]);
        for (int k = 0; k < 9; k++)
            if (k != 4) acc -= int'(win[k][sh +: 8]);
        if (acc < 0) return 8'd0;
        if (acc > 255) return 8'd255;
        return acc[7:0];
    endfunction

    // Advance the prediction by one accepted input beat
    task automatic predict_edge(pix_beat_t b);
        int w, h, total;
        logic [23:0] colv [3];
        edge_beat_t e;
        w = eff_w();
        h = eff_h();
        e = '0;
        if (b.op == OP_DRAIN) begin
            total = (h == 1) ? w : w + 1;
            if (!full_frame) return;
            drained++;
            if (drained >= total) begin
                e.last = 1'b1;
                col_at = 0; row_at = 0; drained = 0; full_frame = 0;
            end
            edge_q.push_back(e);
            return;
        end
        if (full_frame || col_at >= w) return;
        colv[0] = up_line[col_at];
        colv[1] = lo_line[col_at];
        colv[2] = {b.blu, b.grn, b.red};
        for (int r = 0; r < 3; r++) begin
            win[r*3] = win[r*3+1];
            win[r*3+1] = win[r*3+2];
            win[r*3+2] = colv[r];
        end
        up_line[col_at] = lo_line[col_at];
        lo_line[col_at] = colv[2];
        if (row_at >= 2 && col_at >= 2) begin
            e.red = clamp_lap(0);
            e.grn = clamp_lap(8);
            e.blu = clamp_lap(16);
        end
        if (row_at >= 2 || (row_at == 1 && col_at >= 1)) edge_q.push_back(e);
        col_at++;
        if (col_at >= w) begin
            col_at = 0;
            row_at++;
            if (row_at >= h) full_frame = 1;
        end
    endtask

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // Drive input beats from the pending queue
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) predict_edge({op_t'(s_tuser), s_tdata});
            if ((!s_tvalid || s_tready)) begin
                if (pend_q.size() > 0 && !hold_send && $urandom_range(99) >= send_idle) begin
                    pix_beat_t b;
                    b = pend_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser <= b.op;
                    s_tdata <= {b.blu, b.grn, b.red};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Check result beats against the oldest prediction
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (edge_q.size() == 0) begin
                    report_mismatch("unexpected beat", m_tdata, -1);
                end else begin
                    edge_beat_t e;
                    e = edge_q.pop_front();
                    if (m_tdata[7:0] !== e.red) report_mismatch("red", m_tdata[7:0], e.red);
                    if (m_tdata[15:8] !== e.grn)
                        report_mismatch("green", m_tdata[15:8], e.grn);
                    if (m_tdata[23:16] !== e.blu)
                        report_mismatch("blue", m_tdata[23:16], e.blu);
                    if (m_tlast !== e.last) report_mismatch("frame_end", m_tlast, e.last);
                end
            end
            m_tready <= ($urandom_range(99) >= recv_idle);
        end
    end

    task automatic wait_drained();
        while (pend_q.size() > 0 || s_tvalid || edge_q.size() > 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    task automatic write_reg(reg_index_t idx, int val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data <= val[CFG_W-1:0];
        if (idx == REG_FRAME_WIDTH) width_reg = val[10:0];
        else height_reg = val[12:0];
        col_at = 0; row_at = 0; drained = 0; full_frame = 0;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic pix_beat_t rand_pix();
        pix_beat_t b;
        b.op = OP_PIXEL;
        b.red = 8'($urandom); b.grn = 8'($urandom); b.blu = 8'($urandom);
        if ($urandom_range(5) == 0) b.red = ($urandom_range(1)) ? 8'hFF : 8'h00;
        return b;
    endfunction

    // Queue one well-formed frame, with an occasional stray beat when noisy is set
    task automatic queue_frame(int w, int h, bit noisy);
        pix_beat_t b;
        int total;
        for (int i = 0; i < w * h; i++) begin
            if (noisy && $urandom_range(15) == 0) begin
                b = rand_pix(); b.op = OP_DRAIN; pend_q.push_back(b);
            end
            pend_q.push_back(rand_pix());
        end
        if (noisy && $urandom_range(3) == 0) pend_q.push_back(rand_pix());
        total = (h == 1) ? w : w + 1;
        for (int i = 0; i < total; i++) begin
            b = rand_pix(); b.op = OP_DRAIN; pend_q.push_back(b);
        end
    endtask

    // Queue a frame sized by the usable register range
    task automatic run_frame(int w, int h, bit noisy);
        int qw, qh;
        write_reg(REG_FRAME_WIDTH, w);
        write_reg(REG_FRAME_HEIGHT, h);
        qw = (w < 1) ? 1 : (w > MAXW) ? MAXW : w;
        qh = (h < 1) ? 1 : (h > 4096) ? 4096 : h;
        queue_frame(qw, qh, noisy);
        wait_drained();
    endtask

    // Start a frame and stop after a few pixels; the next register write restarts it
    task automatic run_partial(int w, int h, int n);
        write_reg(REG_FRAME_WIDTH, w);
        write_reg(REG_FRAME_HEIGHT, h);
        for (int i = 0; i < n; i++) pend_q.push_back(rand_pix());
        wait_drained();
    endtask

    initial begin
        pix_beat_t b;
        int sent;
        width_reg = 11'd1024;
        height_reg = 13'd1024;
        col_at = 0; row_at = 0; drained = 0; full_frame = 0;
        for (int i = 0; i < 9; i++) win[i] = '0;
        for (int i = 0; i < MAXW; i++) begin up_line[i] = '0; lo_line[i] = '0; end
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: extremes on a 4x4 frame, early drain, late pixel
        write_reg(REG_FRAME_WIDTH, 4);
        write_reg(REG_FRAME_HEIGHT, 4);
        b = '0; b.op = OP_DRAIN; pend_q.push_back(b);
        for (int i = 0; i < 16; i++) begin
            b = '0; b.op = OP_PIXEL;
            if (i == 5 || i == 10) b = {OP_PIXEL, 24'hFFFFFF};
            pend_q.push_back(b);
        end
        b = {OP_PIXEL, 24'hFFFFFF}; pend_q.push_back(b);
        for (int i = 0; i < 5; i++) begin b = '0; b.op = OP_DRAIN; pend_q.push_back(b); end
        wait_drained();

        // Tiny and out-of-range register values
        run_frame(0, 0, 0);
        run_frame(2, 1, 0);
        run_frame(1, 3, 0);
        run_frame(3, 2, 0);
        run_partial(2047, 3, 40);
        run_partial(5, 8191, 20);
        run_frame(3, 3, 0);

        // Random frames across three idling phases
        for (int ph = 0; ph < 3; ph++) begin
            send_idle = (ph == 0) ? 21 : (ph == 1) ? 57 : 0;
            recv_idle = (ph == 0) ? 57 : (ph == 1) ? 21 : 0;
            sent = 0;
            while (sent < 440) begin
                int w, h;
                w = ($urandom_range(7) == 0) ? $urandom_range(1, 40) : $urandom_range(3, 12);
                h = $urandom_range(1, 8);
                run_frame(w, h, 1);
                sent += w * h;
            end
            if (ph == 0) begin
                // Hold the sender until all results are out, mid-frame
                write_reg(REG_FRAME_WIDTH, 6);
                write_reg(REG_FRAME_HEIGHT, 5);
                queue_frame(6, 5, 0);
                while (pend_q.size() > 20) @(posedge aclk);
                hold_send = 1'b1;
                while (s_tvalid || edge_q.size() > 0) @(posedge aclk);
                hold_send = 1'b0;
                wait_drained();
            end
        end

        repeat (20) @(posedge aclk);
        if (errors == 0) $display("ALL CHECKS PASSED");
        else $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        #20ms;
        $display("CHECKS FAILED");
        $finish;
    end
endmodule
`default_nettype wire

>>> sim.f
+incdir+hdl
hdl/ed_pkg.sv
hdl/ed_queue.sv
hdl/ed_front.sv
hdl/ed_back.sv
hdl/edge_detect_3x3.sv
tb/tb_edge_detect_3x3.sv
